### rtl/core/fobh_pkg.sv
package fobh_pkg;

  // Field and datapath widths
  localparam int COMP_W   = 16;
  localparam int ANGLE_W  = 16;
  localparam int BIN_W    = 6;
  localparam int NB_W     = 7;
  localparam int HASH_W   = 3 * BIN_W;
  localparam int STEPS    = 30;
  localparam int STEP_W   = $clog2(STEPS);
  localparam int GUARD_W  = 60 - COMP_W;
  localparam int XY_W     = 64;
  localparam int ACC_W    = 32;
  localparam int LANES    = 3;

  // Lane order inside the rotation chain
  localparam int LANE_ALPHA = 0;
  localparam int LANE_BETA  = 1;
  localparam int LANE_GAMMA = 2;

  localparam logic [NB_W-1:0]  NUM_BINS_RESET = NB_W'(36);
  localparam logic [NB_W-1:0]  NUM_BINS_MAX   = NB_W'(1) << BIN_W;
  localparam logic [ACC_W-1:0] HALF_TURN      = ACC_W'(1) << (ACC_W - 1);
  localparam logic [ACC_W-1:0] ROUND_HALF     = ACC_W'(1) << (ACC_W - ANGLE_W - 1);

  typedef struct packed {
    logic signed [COMP_W-1:0] y_axis_y;
    logic signed [COMP_W-1:0] y_axis_z;
    logic signed [COMP_W-1:0] z_axis_x;
    logic signed [COMP_W-1:0] z_axis_z;
    logic signed [COMP_W-1:0] x_axis_x;
    logic signed [COMP_W-1:0] x_axis_y;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] alpha_angle;
    logic [ANGLE_W-1:0] beta_angle;
    logic [ANGLE_W-1:0] gamma_angle;
    logic [BIN_W-1:0]   alpha_bin;
    logic [BIN_W-1:0]   beta_bin;
    logic [BIN_W-1:0]   gamma_bin;
    logic [HASH_W-1:0]  orientation_hash;
  } out_t;

  // One vectoring lane: rotated vector, angle accumulator, null-vector flag
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [ACC_W-1:0]       acc;
    logic                   zero;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
  } cordic_t;

  // Arctangent of 2^-i in units of 2^32 per turn
  function automatic logic [ACC_W-1:0] atan_step(input logic [STEP_W-1:0] i);
    logic [ACC_W-1:0] t;
    case (i)
      5'd0:    t = 32'd536870912;
      5'd1:    t = 32'd316933406;
      5'd2:    t = 32'd167458907;
      5'd3:    t = 32'd85004756;
      5'd4:    t = 32'd42667331;
      5'd5:    t = 32'd21354465;
      5'd6:    t = 32'd10679838;
      5'd7:    t = 32'd5340245;
      5'd8:    t = 32'd2670163;
      5'd9:    t = 32'd1335087;
      5'd10:   t = 32'd667544;
      5'd11:   t = 32'd333772;
      5'd12:   t = 32'd166886;
      5'd13:   t = 32'd83443;
      5'd14:   t = 32'd41722;
      5'd15:   t = 32'd20861;
      5'd16:   t = 32'd10430;
      5'd17:   t = 32'd5215;
      5'd18:   t = 32'd2608;
      5'd19:   t = 32'd1304;
      5'd20:   t = 32'd652;
      5'd21:   t = 32'd326;
      5'd22:   t = 32'd163;
      5'd23:   t = 32'd81;
      5'd24:   t = 32'd41;
      5'd25:   t = 32'd20;
      5'd26:   t = 32'd10;
      5'd27:   t = 32'd5;
      5'd28:   t = 32'd3;
      5'd29:   t = 32'd1;
      default: t = '0;
    endcase
    return t;
  endfunction

  // Fold the vector into the right half plane and scale it up by the guard bits
  function automatic lane_t prep_lane(input logic signed [COMP_W-1:0] xs,
                                      input logic signed [COMP_W-1:0] ys);
    logic              neg;
    logic [COMP_W:0]   xa;
    logic [COMP_W:0]   ya;
    lane_t             l;
    neg = xs[COMP_W-1];
    xa  = {xs[COMP_W-1], xs};
    ya  = {ys[COMP_W-1], ys};
    if (neg) begin
      xa = -xa;
      ya = -ya;
    end
    l.x    = {{(XY_W-COMP_W-1-GUARD_W){xa[COMP_W]}}, xa, {GUARD_W{1'b0}}};
    l.y    = {{(XY_W-COMP_W-1-GUARD_W){ya[COMP_W]}}, ya, {GUARD_W{1'b0}}};
    l.acc  = neg ? HALF_TURN : '0;
    l.zero = (xs == '0) && (ys == '0);
    return l;
  endfunction

  // Round the accumulator half up to a binary angle; the null vector gives 0
  function automatic logic [ANGLE_W-1:0] lane_angle(input lane_t l);
    logic [ACC_W-1:0] r;
    r = l.acc + ROUND_HALF;
    return l.zero ? '0 : r[ACC_W-1:ACC_W-ANGLE_W];
  endfunction

endpackage

### rtl/core/fobh_cordic_cell.sv
module fobh_cordic_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [fobh_pkg::STEP_W-1:0]  step,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  fobh_pkg::cordic_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output fobh_pkg::cordic_t            out_data
);
  import fobh_pkg::*;

  logic             valid_r;
  cordic_t          data_r;
  cordic_t          data_nxt;
  logic [ACC_W-1:0] atan_val;

  assign atan_val = atan_step(step);

  // One vectoring rotation on each lane, direction from the sign of y
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   y_neg;

    assign xs    = in_data.lane[l].x;
    assign ys    = in_data.lane[l].y;
    assign dx    = ys >>> step;
    assign dy    = xs >>> step;
    assign y_neg = ys[XY_W-1];

    assign data_nxt.lane[l].x    = y_neg ? (xs - dx) : (xs + dx);
    assign data_nxt.lane[l].y    = y_neg ? (ys + dy) : (ys - dy);
    assign data_nxt.lane[l].acc  = y_neg ? (in_data.lane[l].acc - atan_val)
                                         : (in_data.lane[l].acc + atan_val);
    assign data_nxt.lane[l].zero = in_data.lane[l].zero;
  end

  // Take a new beat whenever this cell is empty or its beat moves on
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/core/fobh_bin_hash.sv
module fobh_bin_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [fobh_pkg::NB_W-1:0]  n_eff,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  fobh_pkg::cordic_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output fobh_pkg::out_t             out_data
);
  import fobh_pkg::*;

  localparam int PROD_W  = ANGLE_W + NB_W;
  localparam int SCALE_W = BIN_W + NB_W;
  localparam int HPROD_W = BIN_W + 2 * NB_W;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  out_t s1_r, s2_r, s3_r, s4_r;
  out_t s1_nxt, s2_nxt, s3_nxt, s4_nxt;

  logic [SCALE_W-1:0] gbn_r, bbn_r;
  logic [SCALE_W-1:0] gbn_nxt, bbn_nxt;

  logic [PROD_W-1:0]  pa, pb, pg;
  logic [HPROD_W-1:0] hsum;

  // Advance each stage when it is empty or the next one advances
  assign en4      = !v4_r || !out_stall;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Stage 1: round accumulators to binary angles
  always_comb begin
    s1_nxt             = '0;
    s1_nxt.alpha_angle = lane_angle(in_data.lane[LANE_ALPHA]);
    s1_nxt.beta_angle  = lane_angle(in_data.lane[LANE_BETA]);
    s1_nxt.gamma_angle = lane_angle(in_data.lane[LANE_GAMMA]);
  end

  // Stage 2: scale each angle by the bin count and keep the integer part
  assign pa = PROD_W'(s1_r.alpha_angle) * PROD_W'(n_eff);
  assign pb = PROD_W'(s1_r.beta_angle) * PROD_W'(n_eff);
  assign pg = PROD_W'(s1_r.gamma_angle) * PROD_W'(n_eff);

  always_comb begin
    s2_nxt           = s1_r;
    s2_nxt.alpha_bin = pa[ANGLE_W+BIN_W-1:ANGLE_W];
    s2_nxt.beta_bin  = pb[ANGLE_W+BIN_W-1:ANGLE_W];
    s2_nxt.gamma_bin = pg[ANGLE_W+BIN_W-1:ANGLE_W];
  end

  // Stage 3: first row of the address products
  assign s3_nxt  = s2_r;
  assign gbn_nxt = SCALE_W'(s2_r.gamma_bin) * SCALE_W'(n_eff);
  assign bbn_nxt = SCALE_W'(s2_r.beta_bin) * SCALE_W'(n_eff);

  // Stage 4: finish the linear bin address
  assign hsum = HPROD_W'(gbn_r) * HPROD_W'(n_eff) + HPROD_W'(bbn_r)
              + HPROD_W'(s3_r.alpha_bin);

  always_comb begin
    s4_nxt                  = s3_r;
    s4_nxt.orientation_hash = hsum[HASH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= s1_nxt;
    end
    if (en2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (en3 && v2_r) begin
      s3_r  <= s3_nxt;
      gbn_r <= gbn_nxt;
      bbn_r <= bbn_nxt;
    end
    if (en4 && v3_r) begin
      s4_r <= s4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = s4_r;

endmodule

### rtl/core/frame_orientation_bin_hash_core.sv
// Orientation bin hash of a local frame. Each input beat carries six axis
// components; three CORDIC vectoring lanes find the alpha, beta and gamma
// angles as 16-bit binary angles (65536 per turn, atan2(0,0) = 0), each angle
// is binned against num_bins and the bins are folded into an 18-bit address
// gamma*n*n + beta*n + alpha. A new frame is taken every cycle unless the
// output stalls. There is one register per rotation step in a chain of
// 30 CORDIC cells, then four stages: rounding, binning, two address multiplies.
// Any stage that is empty takes a beat even while the output is stalled, so
// bubbles close up. num_bins resets to 36; 0 counts as 1 and values above 64
// count as 64. Write num_bins only while no frame is in flight.
module frame_orientation_bin_hash_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  fobh_pkg::in_t             in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output fobh_pkg::out_t            out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [fobh_pkg::NB_W-1:0] cfg_data
);
  import fobh_pkg::*;

  logic [NB_W-1:0] num_bins_r;
  logic [NB_W-1:0] n_eff;

  logic    chain_v   [0:STEPS];
  logic    chain_rdy [0:STEPS];
  cordic_t chain_d   [0:STEPS];

  // Bin count register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= NUM_BINS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_bins_r <= cfg_data;
    end
  end

  // Clamp the bin count to 1..64
  always_comb begin
    if (num_bins_r == '0) begin
      n_eff = NB_W'(1);
    end else if (num_bins_r > NUM_BINS_MAX) begin
      n_eff = NUM_BINS_MAX;
    end else begin
      n_eff = num_bins_r;
    end
  end

  // Fold each vector into the right half plane ahead of the first cell
  assign chain_v[0] = in_valid;
  assign in_stall   = !chain_rdy[0];
  assign chain_d[0].lane[LANE_ALPHA] = prep_lane(in_data.y_axis_y, in_data.y_axis_z);
  assign chain_d[0].lane[LANE_BETA]  = prep_lane(in_data.z_axis_z, in_data.z_axis_x);
  assign chain_d[0].lane[LANE_GAMMA] = prep_lane(in_data.x_axis_x, in_data.x_axis_y);

  // Rotation chain, one step per cell
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    fobh_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (STEP_W'(g)),
      .in_valid  (chain_v[g]),
      .in_ready  (chain_rdy[g]),
      .in_data   (chain_d[g]),
      .out_valid (chain_v[g+1]),
      .out_ready (chain_rdy[g+1]),
      .out_data  (chain_d[g+1])
    );
  end

  fobh_bin_hash u_bin_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_eff     (n_eff),
    .in_valid  (chain_v[STEPS]),
    .in_ready  (chain_rdy[STEPS]),
    .in_data   (chain_d[STEPS]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An empty first cell never pushes back on the input
  a_front_open: assert property (@(posedge clk) disable iff (!rst_n)
    !chain_v[1] |-> !in_stall)
    else $error("input stalled with empty first cell");

  // Every bin lies below the clamped bin count
  a_bins_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_data.alpha_bin} < n_eff) &&
                  ({1'b0, out_data.beta_bin} < n_eff) &&
                  ({1'b0, out_data.gamma_bin} < n_eff))
    else $error("bin index not below bin count");

  // A zero angle always lands in bin zero
  a_zero_angle_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.alpha_angle == '0) |-> (out_data.alpha_bin == '0))
    else $error("zero alpha angle in non-zero bin");

  // A single bin per axis gives address zero
  a_single_bin_hash: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (n_eff == NB_W'(1)) |-> (out_data.orientation_hash == '0))
    else $error("non-zero address with one bin");

endmodule
